// ===== sv/arsa_pkg.sv =====
// Shared types and constants for the aligned ring space allocator.
`default_nettype none

package arsa_pkg;

   localparam int CAP_BITS       = 24;             // largest usable capacity is 2**CAP_BITS
   localparam int CAP_W          = CAP_BITS + 1;   // capacity register width
   localparam int PHYS_W         = CAP_BITS;       // position inside the buffer
   localparam int MAX_ALIGN_LOG2 = 12;
   localparam int ALOG_W         = 4;
   localparam int PAD_W          = 12;             // padding is below 2**MAX_ALIGN_LOG2
   localparam int BASE_W         = 12;
   localparam int SIZE_W         = 25;
   localparam int POS_W          = 64;
   localparam int CNT_W          = $clog2(POS_W);

   localparam logic [CAP_W-1:0]  CAP_LIMIT   = CAP_W'(1) << CAP_BITS;
   localparam logic [ALOG_W-1:0] ALOG_LIMIT  = ALOG_W'(MAX_ALIGN_LOG2);

   // Stream payload layout
   localparam int REQ_DATA_W  = 96;
   localparam int REQ_SIZE_LO = 0;
   localparam int REQ_ALOG_LO = REQ_SIZE_LO + SIZE_W;
   localparam int REQ_MARK_LO = REQ_ALOG_LO + ALOG_W;
   localparam int RSP_DATA_W  = 88;
   localparam int RSP_OFF_LO  = 0;
   localparam int RSP_HEAD_LO = RSP_OFF_LO + PHYS_W;

   // Item kinds carried in req_tuser
   localparam logic MODE_ALLOC  = 1'b0;
   localparam logic MODE_RETIRE = 1'b1;

   // Register map
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_CAPACITY = 1'b0;
   localparam logic REG_BASE_LOW = 1'b1;

   typedef struct packed {
      logic load_item;
      logic retire;
      logic refuse;
      logic mod_start;
      logic mod_load;
      logic align;
      logic fit;
      logic advance;
      logic check;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_retire;
      logic pre_ok;
      logic stale;
      logic mod_done;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== sv/aligned_ring_space_allocator_top.sv =====
// Top level of the aligned ring space allocator: register port, sequencer and datapath.
`default_nettype none

// Hands out aligned, contiguous regions of a circular buffer and retires them by
// stream position. One item is in work at a time. A retire item, or an allocate item
// that is refused up front (zero capacity, zero or oversized request), goes from decide
// straight to output; one that reaches the fit test passes align, fit, advance and check.
// After a capacity write (or a head position that wrapped past 2**64) the next allocate
// item not refused first recomputes head mod capacity in a bit-serial remainder unit.
// The result sits in an output register, so the next item is taken while an earlier
// result is still waiting. Write configuration only while idle.

module aligned_ring_space_allocator_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // item channel
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic                                req_tuser,  // mode
   input  wire logic [arsa_pkg::REQ_DATA_W-1:0]     req_tdata,  // size_bytes, align_log2, retire_marker
   // result channel
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic                                     rsp_tuser,  // ok
   output logic [arsa_pkg::RSP_DATA_W-1:0]          rsp_tdata,  // offset, head_position
   // register port
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [arsa_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [31:0]                         csr_pwdata,
   output logic [31:0]                              csr_prdata,
   output logic                                     csr_pready
);

   logic [arsa_pkg::CAP_W-1:0]  capacity_ff;
   logic [arsa_pkg::BASE_W-1:0] base_ff;
   logic                        wr_en;
   logic                        cap_wr;
   logic                        base_wr;

   arsa_pkg::ctrl_cmd_type  cmd;
   arsa_pkg::dp_status_type sts;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cap_wr     = wr_en && (csr_paddr[2] == arsa_pkg::REG_CAPACITY);
   assign base_wr    = wr_en && (csr_paddr[2] == arsa_pkg::REG_BASE_LOW);

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= '0;
         base_ff     <= '0;
      end else begin
         if (cap_wr) begin
            capacity_ff <= csr_pwdata[arsa_pkg::CAP_W-1:0];
         end
         if (base_wr) begin
            base_ff <= csr_pwdata[arsa_pkg::BASE_W-1:0];
         end
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         arsa_pkg::REG_CAPACITY: csr_prdata = 32'(capacity_ff);
         arsa_pkg::REG_BASE_LOW: csr_prdata = 32'(base_ff);
         default:                csr_prdata = '0;
      endcase
   end

   arsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   arsa_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .capacity   (capacity_ff),
      .base_low   (base_ff),
      .cap_wr     (cap_wr),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// ===== sv/arsa_mod.sv =====
// Bit-serial remainder unit: 64-bit stream position modulo the capacity.
`default_nettype none

module arsa_mod (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [arsa_pkg::POS_W-1:0]   dividend,
   input  wire logic [arsa_pkg::CAP_W-1:0]   divisor,
   output logic                              done,
   output logic [arsa_pkg::PHYS_W-1:0]       remainder
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [arsa_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic [arsa_pkg::POS_W-1:0]      dvd_ff, dvd_in;
   logic [arsa_pkg::PHYS_W-1:0]     rem_ff, rem_in;
   logic [arsa_pkg::CAP_W-1:0]      shifted;

   // one quotient bit per cycle, MSB first
   assign shifted = {rem_ff, dvd_ff[arsa_pkg::POS_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[arsa_pkg::POS_W-2:0], 1'b0};
         if (shifted >= divisor) begin
            rem_in = arsa_pkg::PHYS_W'(shifted - divisor);
         end else begin
            rem_in = arsa_pkg::PHYS_W'(shifted);
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == arsa_pkg::CNT_W'(arsa_pkg::POS_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== sv/arsa_ctrl.sv =====
// Allocator sequencer: decide, then as needed mod, align, fit, advance, check; output.
`default_nettype none

module arsa_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire arsa_pkg::dp_status_type sts,
   output arsa_pkg::ctrl_cmd_type       cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECIDE = 3'd1;
   localparam logic [2:0] ST_MOD    = 3'd2;
   localparam logic [2:0] ST_ALIGN  = 3'd3;
   localparam logic [2:0] ST_FIT    = 3'd4;
   localparam logic [2:0] ST_ADV    = 3'd5;
   localparam logic [2:0] ST_CHECK  = 3'd6;
   localparam logic [2:0] ST_OUT    = 3'd7;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            priority if (sts.is_retire) begin
               cmd.retire = 1'b1;
               state_in   = ST_OUT;
            end else if (!sts.pre_ok) begin
               cmd.refuse = 1'b1;
               state_in   = ST_OUT;
            end else if (sts.stale) begin
               cmd.mod_start = 1'b1;
               state_in      = ST_MOD;
            end else begin
               state_in = ST_ALIGN;
            end
         end
         ST_MOD: begin
            if (sts.mod_done) begin
               cmd.mod_load = 1'b1;
               state_in     = ST_ALIGN;
            end
         end
         ST_ALIGN: begin
            cmd.align = 1'b1;
            state_in  = ST_FIT;
         end
         ST_FIT: begin
            cmd.fit  = 1'b1;
            state_in = ST_ADV;
         end
         ST_ADV: begin
            cmd.advance = 1'b1;
            state_in    = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

`default_nettype wire

// ===== sv/arsa_dp.sv =====
// Allocator datapath: head/tail positions, alignment and fit arithmetic, result register.
`default_nettype none

module arsa_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire arsa_pkg::ctrl_cmd_type              cmd,
   output arsa_pkg::dp_status_type                  sts,
   input  wire logic                                req_tuser,
   input  wire logic [arsa_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire logic [arsa_pkg::CAP_W-1:0]          capacity,
   input  wire logic [arsa_pkg::BASE_W-1:0]         base_low,
   input  wire logic                                cap_wr,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic                                     rsp_tuser,
   output logic [arsa_pkg::RSP_DATA_W-1:0]          rsp_tdata
);

   localparam int PW = arsa_pkg::POS_W;
   localparam int CW = arsa_pkg::CAP_W;
   localparam int XW = arsa_pkg::PHYS_W;
   localparam int DW = arsa_pkg::PAD_W;
   localparam int SW = arsa_pkg::SIZE_W;

   // persistent state
   logic [PW-1:0] head_ff, tail_ff;
   logic [XW-1:0] phys_ff;          // head_ff mod capacity
   logic          phys_ok_ff;

   // current item
   logic          mode_ff;
   logic [SW-1:0] size_ff;
   logic [arsa_pkg::ALOG_W-1:0] alog_ff, alog_in;
   logic [PW-1:0] mark_ff;

   // working registers
   logic [DW-1:0] pad1_ff, pad2_ff;
   logic          fits_ff;
   logic [XW-1:0] off_ff;
   logic [CW-1:0] delta_ff;
   logic [PW-1:0] cand_ff;
   logic          carry_ff;
   logic [XW-1:0] nphys_ff;
   logic          res_ok_ff;
   logic [XW-1:0] res_off_ff;

   // output register
   logic          rsp_valid_ff;
   logic          rsp_ok_ff;
   logic [XW-1:0] rsp_off_ff;
   logic [PW-1:0] rsp_head_ff;

   logic [CW-1:0] cap_eff;
   logic [DW-1:0] mask;
   logic [CW-1:0] addr1;
   logic [CW:0]   up1, al1;
   logic [DW:0]   up2, al2;
   logic [CW:0]   sum1, sum2;
   logic          fit1, fit2;
   logic [CW:0]   adv_small;
   logic [PW:0]   adv_sum;
   logic [CW-1:0] nphys_raw;
   logic [PW-1:0] used;
   logic          grant;
   logic          mod_done;
   logic [XW-1:0] mod_rem;

   arsa_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mod_start),
      .dividend  (head_ff),
      .divisor   (cap_eff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign cap_eff = (capacity > arsa_pkg::CAP_LIMIT) ? arsa_pkg::CAP_LIMIT : capacity;
   assign mask    = ~({DW{1'b1}} << alog_ff);

   always_comb begin
      alog_in = req_tdata[arsa_pkg::REQ_ALOG_LO +: arsa_pkg::ALOG_W];
      if (alog_in > arsa_pkg::ALOG_LIMIT) begin
         alog_in = arsa_pkg::ALOG_LIMIT;
      end
   end

   // padding from the current head, and from the buffer start after a wrap
   assign addr1 = CW'(base_low) + CW'(phys_ff);
   assign up1   = (CW+1)'(addr1) + (CW+1)'(mask);
   assign al1   = up1 & ~((CW+1)'(mask));
   assign up2   = (DW+1)'(base_low) + (DW+1)'(mask);
   assign al2   = up2 & ~((DW+1)'(mask));

   assign sum1 = (CW+1)'(phys_ff) + (CW+1)'(pad1_ff) + (CW+1)'(size_ff);
   assign sum2 = (CW+1)'(pad2_ff) + (CW+1)'(size_ff);
   assign fit1 = sum1 <= (CW+1)'(cap_eff);
   assign fit2 = sum2 <= (CW+1)'(cap_eff);

   assign adv_small = (CW+1)'(delta_ff) + (CW+1)'(size_ff);
   assign adv_sum   = (PW+1)'(head_ff) + (PW+1)'(adv_small);
   assign nphys_raw = CW'(off_ff) + CW'(size_ff);

   assign used  = cand_ff - tail_ff;
   assign grant = fits_ff && (used <= PW'(cap_eff));

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         phys_ff      <= '0;
         phys_ok_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cap_wr) begin
            phys_ok_ff <= 1'b0;
         end else if (cmd.mod_load) begin
            phys_ff    <= mod_rem;
            phys_ok_ff <= 1'b1;
         end else if (cmd.check && grant) begin
            head_ff    <= cand_ff;
            phys_ff    <= nphys_ff;
            // a position that wrapped past 2**64 no longer tracks phys_ff
            phys_ok_ff <= !carry_ff;
         end
         if (cmd.retire && (mark_ff > tail_ff)) begin
            tail_ff <= (mark_ff < head_ff) ? mark_ff : head_ff;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         mode_ff <= req_tuser;
         size_ff <= req_tdata[arsa_pkg::REQ_SIZE_LO +: SW];
         alog_ff <= alog_in;
         mark_ff <= req_tdata[arsa_pkg::REQ_MARK_LO +: PW];
      end
      if (cmd.align) begin
         pad1_ff <= DW'(al1 - (CW+1)'(addr1));
         pad2_ff <= DW'(al2 - (DW+1)'(base_low));
      end
      if (cmd.fit) begin
         fits_ff <= fit1 || fit2;
         if (fit1) begin
            off_ff   <= XW'(phys_ff) + XW'(pad1_ff);
            delta_ff <= CW'(pad1_ff);
         end else begin
            off_ff   <= XW'(pad2_ff);
            delta_ff <= cap_eff - CW'(phys_ff) + CW'(pad2_ff);
         end
      end
      if (cmd.advance) begin
         cand_ff  <= adv_sum[PW-1:0];
         carry_ff <= adv_sum[PW];
         nphys_ff <= (nphys_raw == cap_eff) ? '0 : XW'(nphys_raw);
      end
      if (cmd.retire) begin
         res_ok_ff  <= 1'b1;
         res_off_ff <= '0;
      end else if (cmd.refuse) begin
         res_ok_ff  <= 1'b0;
         res_off_ff <= '0;
      end else if (cmd.check) begin
         res_ok_ff  <= grant;
         res_off_ff <= grant ? off_ff : '0;
      end
      if (cmd.emit) begin
         rsp_ok_ff   <= res_ok_ff;
         rsp_off_ff  <= res_off_ff;
         rsp_head_ff <= head_ff;
      end
   end

   always_comb begin
      sts.is_retire = (mode_ff == arsa_pkg::MODE_RETIRE);
      sts.pre_ok    = (cap_eff != '0) && (size_ff != '0) && (size_ff <= cap_eff);
      sts.stale     = !phys_ok_ff;
      sts.mod_done  = mod_done;
      sts.out_free  = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = {rsp_head_ff, rsp_off_ff};

   // cached physical head must stay inside the buffer
   a_phys_in_range: assert property (@(posedge clock) disable iff (reset)
      (phys_ok_ff && cap_eff != '0) |-> (phys_ff < cap_eff))
      else $error("cached head offset outside buffer");

   // a granted region always starts inside the buffer
   a_grant_offset: assert property (@(posedge clock) disable iff (reset)
      (cmd.check && grant) |-> (CW'(off_ff) < cap_eff))
      else $error("granted offset outside buffer");

   // the head moves only when an allocation is committed
   a_head_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.check |=> $stable(head_ff))
      else $error("head moved without a grant");

endmodule

`default_nettype wire
